### sv/rzn_pkg.sv
// shared types and constants for the remapped zero-run nibble encoder
// no dependencies
`default_nettype none
package rzn_pkg;

  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned NIBBLE_W   = 4;
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned MAX_OUT    = 4;

  localparam logic [NIBBLE_W-1:0] RUN_MAX = 4'hF;

  localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ENCODE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd2;

  // command word handed from the front to the back
  typedef struct packed {
    logic              flush;
    logic [BYTE_W-1:0] code;
  } cmd_t;

endpackage : rzn_pkg
`default_nettype wire

### sv/rzn_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module rzn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule : rzn_ram
`default_nettype wire

### sv/rzn_front.sv
// front end: accepts input words, writes the code table, looks up codes
// depends on rzn_pkg and rzn_ram
`default_nettype none
module rzn_front
  import rzn_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire logic [ACTION_W-1:0] in_action,
  input  wire logic [BYTE_W-1:0]   in_byte_value,
  input  wire logic [BYTE_W-1:0]   in_code_value,
  output      logic                in_full,
  output      logic                q_push,
  output      cmd_t                q_cmd,
  input  wire logic                q_full
);

  logic              acc;
  logic              tbl_we;
  logic              tbl_re;
  logic [BYTE_W-1:0] tbl_rdata;
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic              s1_flush_r;
  logic              s1_flush_nxt;
  logic              takes_slot;

  assign in_full = s1_valid_r && q_full;
  assign acc     = in_push && !in_full;
  assign tbl_we  = acc && (in_action == ACT_LOAD);
  assign tbl_re  = acc && (in_action == ACT_ENCODE);
  // loads and the unused action leave nothing for the back end
  assign takes_slot = acc && ((in_action == ACT_ENCODE) || (in_action == ACT_FLUSH));
  assign q_push  = s1_valid_r && !q_full;

  rzn_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_byte_value),
    .wdata (in_code_value),
    .re    (tbl_re),
    .raddr (in_byte_value),
    .rdata (tbl_rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_flush_nxt = s1_flush_r;
    if (takes_slot) begin
      s1_valid_nxt = 1'b1;
      s1_flush_nxt = (in_action == ACT_FLUSH);
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    s1_flush_r <= s1_flush_nxt;
  end

  // ram read data holds while the stage is stalled since no read is issued
  assign q_cmd.flush = s1_flush_r;
  assign q_cmd.code  = tbl_rdata;

endmodule : rzn_front
`default_nettype wire

### sv/rzn_fifo.sv
// short command queue between the front and back ends
// depends on rzn_pkg
`default_nettype none
module rzn_fifo
  import rzn_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output      logic full,
  input  wire logic pop,
  output      cmd_t pop_cmd,
  output      logic empty
);

  localparam int unsigned AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  cmd_t          slot_r [FIFO_DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(FIFO_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
    if (do_push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

endmodule : rzn_fifo
`default_nettype wire

### sv/rzn_back.sv
// back end: scans codes for zero runs, packs nibbles and drains result words
// depends on rzn_pkg
`default_nettype none
module rzn_back
  import rzn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire cmd_t              q_cmd,
  output      logic              q_pop,
  output      logic              out_empty,
  input  wire logic              out_pop,
  output      logic [BYTE_W-1:0] out_byte,
  output      logic              out_last_of_run,
  output      logic              out_run_overflow
);

  localparam int unsigned IW = $clog2(MAX_OUT);
  localparam int unsigned NW = $clog2(MAX_OUT + 1);

  // run state
  logic [NIBBLE_W-1:0] zero_run_r, zero_run_nxt;
  logic                hi_pend_r, hi_pend_nxt;
  logic [NIBBLE_W-1:0] pend_lo_r, pend_lo_nxt;

  // words produced by one command, waiting to drain
  logic [BYTE_W-1:0] buf_byte_r [MAX_OUT];
  logic [MAX_OUT-1:0] buf_ovf_r;
  logic [NW-1:0]      rem_r, rem_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;

  // output register
  logic              ovalid_r, ovalid_nxt;
  logic [BYTE_W-1:0] obyte_r;
  logic              olast_r;
  logic              oovf_r;

  // scan results
  logic [BYTE_W-1:0]  new_byte [MAX_OUT];
  logic [MAX_OUT-1:0] new_ovf;
  logic [NW-1:0]      new_cnt;
  logic [NIBBLE_W-1:0] sc_run;
  logic                sc_hp;
  logic [NIBBLE_W-1:0] sc_lo;

  logic mv;
  logic take;

  assign mv    = (rem_r != '0) && (!ovalid_r || out_pop);
  assign take  = !q_empty && ((rem_r == '0) || ((rem_r == NW'(1)) && mv));
  assign q_pop = take;

  // bit scan, least significant first, over one code word; a flush closes any held low nibble instead
  always_comb begin
    sc_run  = zero_run_r;
    sc_hp   = hi_pend_r;
    sc_lo   = pend_lo_r;
    new_cnt = '0;
    new_ovf = '0;
    for (int k = 0; k < MAX_OUT; k++) begin
      new_byte[k] = '0;
    end
    if (q_cmd.flush) begin
      if (sc_hp) begin
        new_byte[0] = {RUN_MAX, sc_lo};
        new_ovf[0]  = (sc_lo == RUN_MAX);
        new_cnt     = NW'(1);
      end
      sc_run = '0;
      sc_hp  = 1'b0;
      sc_lo  = '0;
    end else begin
      for (int i = 0; i < BYTE_W; i++) begin
        if (!q_cmd.code[i]) begin
          if (sc_run != RUN_MAX) begin
            sc_run = sc_run + 1'b1;
          end
        end else begin
          if (!sc_hp) begin
            sc_lo = sc_run;
            sc_hp = 1'b1;
          end else begin
            new_byte[new_cnt[IW-1:0]] = {sc_run, sc_lo};
            new_ovf[new_cnt[IW-1:0]]  = (sc_lo == RUN_MAX) || (sc_run == RUN_MAX);
            new_cnt = new_cnt + 1'b1;
            sc_hp   = 1'b0;
            sc_lo   = '0;
          end
          sc_run = '0;
        end
      end
    end
  end

  always_comb begin
    zero_run_nxt = zero_run_r;
    hi_pend_nxt  = hi_pend_r;
    pend_lo_nxt  = pend_lo_r;
    rem_nxt      = rem_r;
    idx_nxt      = idx_r;
    ovalid_nxt   = ovalid_r;
    if (out_pop && ovalid_r) begin
      ovalid_nxt = 1'b0;
    end
    if (mv) begin
      ovalid_nxt = 1'b1;
      rem_nxt    = rem_r - 1'b1;
      idx_nxt    = idx_r + 1'b1;
    end
    if (take) begin
      zero_run_nxt = sc_run;
      hi_pend_nxt  = sc_hp;
      pend_lo_nxt  = sc_lo;
      rem_nxt      = new_cnt;
      idx_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r <= '0;
      hi_pend_r  <= 1'b0;
      pend_lo_r  <= '0;
      rem_r      <= '0;
      idx_r      <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      zero_run_r <= zero_run_nxt;
      hi_pend_r  <= hi_pend_nxt;
      pend_lo_r  <= pend_lo_nxt;
      rem_r      <= rem_nxt;
      idx_r      <= idx_nxt;
      ovalid_r   <= ovalid_nxt;
    end
    if (take) begin
      for (int k = 0; k < MAX_OUT; k++) begin
        buf_byte_r[k] <= new_byte[k];
      end
      buf_ovf_r <= new_ovf;
    end
    if (mv) begin
      obyte_r <= buf_byte_r[idx_r];
      oovf_r  <= buf_ovf_r[idx_r];
      olast_r <= (rem_r == NW'(1));
    end
  end

  assign out_empty        = !ovalid_r;
  assign out_byte         = obyte_r;
  assign out_last_of_run  = olast_r;
  assign out_run_overflow = oovf_r;

endmodule : rzn_back
`default_nettype wire

### sv/remapped_zero_run_nibble_encoder_unit.sv
// Remapped zero-run nibble encoder, top level.
// Input words come in on a queue-style port: a word is taken when in_push is
// high and in_full is low. Action load writes in_code_value into the code
// table at in_byte_value, encode looks the byte up and emits zero-run nibbles
// of the code, flush closes a half-filled output byte with 15.
// Result words leave on a queue-style port: out_byte and its flags are valid
// while out_empty is low and are taken when out_pop is high.
// An encode or flush word passes the front stage with its table read, the
// command queue, the scan buffer and the output register to the out_ ports.
// Throughput: one input word a cycle when it yields at most one result and the
// receiver keeps popping; an encode yielding up to four result bytes holds the
// back end until its last byte moves into the single-byte result register.
// A two-entry command queue lets the front keep taking words (loads need no
// back end) while the back drains; when the receiver stalls the back end and
// queue fill and in_full rises.
// Reset (synchronous, rst_n low) clears the run state and all queues; the code
// table is not cleared and must be loaded before its entries are used.
// depends on rzn_pkg, rzn_front, rzn_fifo, rzn_back
`default_nettype none
module remapped_zero_run_nibble_encoder_unit
  import rzn_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output      logic                in_full,
  input  wire logic [ACTION_W-1:0] in_action,
  input  wire logic [BYTE_W-1:0]   in_byte_value,
  input  wire logic [BYTE_W-1:0]   in_code_value,
  output      logic                out_empty,
  input  wire logic                out_pop,
  output      logic [BYTE_W-1:0]   out_byte,
  output      logic                out_last_of_run,
  output      logic                out_run_overflow
);

  logic f_push;
  cmd_t f_cmd;
  logic f_full;
  logic b_pop;
  cmd_t b_cmd;
  logic b_empty;

  rzn_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_action     (in_action),
    .in_byte_value (in_byte_value),
    .in_code_value (in_code_value),
    .in_full       (in_full),
    .q_push        (f_push),
    .q_cmd         (f_cmd),
    .q_full        (f_full)
  );

  rzn_fifo u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_cmd (f_cmd),
    .full     (f_full),
    .pop      (b_pop),
    .pop_cmd  (b_cmd),
    .empty    (b_empty)
  );

  rzn_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (b_empty),
    .q_cmd            (b_cmd),
    .q_pop            (b_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run),
    .out_run_overflow (out_run_overflow)
  );

endmodule : remapped_zero_run_nibble_encoder_unit
`default_nettype wire

### bench/tb_remapped_zero_run_nibble_encoder_unit.sv
// testbench for remapped_zero_run_nibble_encoder_unit: table loads, encodes and flushes
// predicted word by word and checked against every popped result byte
// depends on rzn_pkg and the encoder unit
`timescale 1ns / 100ps
module tb_remapped_zero_run_nibble_encoder_unit;
  import rzn_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 12;
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last_flag;
    logic              ovf_flag;
  } packed_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  logic [ACTION_W-1:0] in_action;
  logic [BYTE_W-1:0]   in_byte_value;
  logic [BYTE_W-1:0]   in_code_value;
  logic                out_empty;
  logic                out_pop;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last_of_run;
  logic                out_run_overflow;

  // encoder image kept alongside the block
  logic [BYTE_W-1:0]   code_mem [TABLE_DEPTH];
  bit                  entry_loaded [TABLE_DEPTH];
  int                  loaded_idx [$];
  logic [NIBBLE_W-1:0] zero_run_len;
  bit                  low_half_held;
  logic [NIBBLE_W-1:0] held_low_nibble;

  packed_result_t      pending_bytes [$];
  packed_result_t      head_byte;

  int  mismatches;
  int  words_sent;
  int  bytes_checked;
  int  overflow_bytes;
  int  quiet_cycles;
  int  hold_left;
  int  pop_gap;
  bit  in_idle_en;
  bit  out_idle_en;

  remapped_zero_run_nibble_encoder_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_action        (in_action),
    .in_byte_value    (in_byte_value),
    .in_code_value    (in_code_value),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run),
    .out_run_overflow (out_run_overflow)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // zero and single-bit codes push runs towards saturation
  function automatic logic [BYTE_W-1:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 35) return BYTE_W'(1) << $urandom_range(0, BYTE_W - 1);
    if (r < 45) return '1;
    return BYTE_W'($urandom_range(1, 255));
  endfunction

  task automatic predict_word(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] idx,
                              input logic [BYTE_W-1:0] code_in);
    logic [BYTE_W-1:0] code;
    packed_result_t    batch [MAX_OUT];
    int                n;
    n = 0;
    case (act)
      ACT_LOAD: begin
        code_mem[idx] = code_in;
        if (!entry_loaded[idx]) loaded_idx = {loaded_idx, int'(idx)};
        entry_loaded[idx] = 1'b1;
      end
      ACT_ENCODE: begin
        code = code_mem[idx];
        for (int i = 0; i < BYTE_W; i++) begin
          if (!code[i]) begin
            if (zero_run_len != RUN_MAX) zero_run_len++;
          end else begin
            if (!low_half_held) begin
              held_low_nibble = zero_run_len;
              low_half_held = 1'b1;
            end else begin
              batch[n].data = {zero_run_len, held_low_nibble};
              batch[n].last_flag = 1'b0;
              batch[n].ovf_flag = (held_low_nibble == RUN_MAX) || (zero_run_len == RUN_MAX);
              n++;
              low_half_held = 1'b0;
              held_low_nibble = '0;
            end
            zero_run_len = '0;
          end
        end
      end
      ACT_FLUSH: begin
        if (low_half_held) begin
          // filler nibble never counts as overflow
          batch[0].data = {RUN_MAX, held_low_nibble};
          batch[0].last_flag = 1'b0;
          batch[0].ovf_flag = (held_low_nibble == RUN_MAX);
          n = 1;
        end
        zero_run_len = '0;
        low_half_held = 1'b0;
        held_low_nibble = '0;
      end
      default: ;
    endcase
    if (n > 0) batch[n-1].last_flag = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (batch[i].ovf_flag) overflow_bytes++;
      pending_bytes = {pending_bytes, batch[i]};
    end
  endtask

  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] idx,
                           input logic [BYTE_W-1:0] code_in);
    int gap;
    @(negedge clk);
    in_push <= 1'b1;
    in_action <= act;
    in_byte_value <= idx;
    in_code_value <= code_in;
    do @(posedge clk); while (in_full);
    predict_word(act, idx, code_in);
    words_sent++;
    gap = pick_gap(in_idle_en);
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // receiver: random pops, or a counted hold-off when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_pop <= 1'b0;
      hold_left--;
    end else if (pop_gap > 0) begin
      out_pop <= 1'b0;
      pop_gap--;
    end else begin
      out_pop <= 1'b1;
      pop_gap = pick_gap(out_idle_en);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected word byte=%02h last=%b ovf=%b",
                                  out_byte, out_last_of_run, out_run_overflow));
      end else begin
        head_byte = pending_bytes.pop_front();
        if (out_byte !== head_byte.data || out_last_of_run !== head_byte.last_flag ||
            out_run_overflow !== head_byte.ovf_flag)
          report_mismatch($sformatf("want byte=%02h last=%b ovf=%b, got byte=%02h last=%b ovf=%b",
                                    head_byte.data, head_byte.last_flag, head_byte.ovf_flag,
                                    out_byte, out_last_of_run, out_run_overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic test_idle_after_reset();
    // flush with nothing held and the unused action both give nothing
    send_word(ACT_FLUSH, 8'hFF, 8'hFF);
    send_word(ACT_UNUSED, 8'h00, 8'h00);
  endtask

  task automatic test_table_extremes();
    send_word(ACT_LOAD, 8'h00, 8'h01);
    send_word(ACT_LOAD, 8'hFF, 8'hFF);
    send_word(ACT_LOAD, 8'h80, 8'h80);
    send_word(ACT_LOAD, 8'h01, 8'h00);
    send_word(ACT_LOAD, 8'h55, 8'hAA);
    send_word(ACT_LOAD, 8'hAA, 8'h55);
    send_word(ACT_ENCODE, 8'hFF, 8'h00);   // four bytes from one word
    send_word(ACT_ENCODE, 8'h00, 8'hFF);
    send_word(ACT_ENCODE, 8'h80, 8'h00);
    send_word(ACT_ENCODE, 8'h55, 8'h00);
    send_word(ACT_ENCODE, 8'hAA, 8'h00);
  endtask

  task automatic test_long_runs();
    // zero codes carry the run across words until it saturates
    send_word(ACT_ENCODE, 8'h01, 8'h00);
    send_word(ACT_ENCODE, 8'h01, 8'h00);
    send_word(ACT_ENCODE, 8'h80, 8'h00);
    send_word(ACT_ENCODE, 8'h00, 8'h00);
    send_word(ACT_ENCODE, 8'h01, 8'h00);
    send_word(ACT_ENCODE, 8'h01, 8'h00);
    send_word(ACT_ENCODE, 8'h80, 8'h00);
    send_word(ACT_FLUSH, 8'h00, 8'h00);    // saturated low half closed by flush
    send_word(ACT_ENCODE, 8'h80, 8'h00);
    send_word(ACT_FLUSH, 8'h00, 8'h00);
    send_word(ACT_ENCODE, 8'h01, 8'h00);
    send_word(ACT_FLUSH, 8'h00, 8'h00);    // partial run dropped, no result
    send_word(ACT_UNUSED, 8'hFF, 8'hFF);
    send_word(ACT_ENCODE, 8'h00, 8'h00);
  endtask

  task automatic test_backpressure();
    in_idle_en = 1'b0;
    hold_left = 300;
    for (int i = 0; i < 12; i++) send_word(ACT_ENCODE, 8'hFF, BYTE_W'($urandom));
    in_idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    int done;
    int r;
    logic [BYTE_W-1:0] idx;
    done = 0;
    for (int i = 0; i < 40; i++) send_word(ACT_LOAD, BYTE_W'($urandom), pick_code());
    while (done < 125) begin
      // alternate stretches with and without idling
      if (done % 50 == 0) begin
        in_idle_en = (done != 50);
        out_idle_en = (done != 100);
      end
      r = $urandom_range(0, 99);
      idx = BYTE_W'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
      if (r < 62) begin
        send_word(ACT_ENCODE, idx, BYTE_W'($urandom));
      end else if (r < 72) begin
        send_word(ACT_LOAD, BYTE_W'($urandom), pick_code());
      end else if (r < 85) begin
        send_word(ACT_FLUSH, BYTE_W'($urandom), BYTE_W'($urandom));
      end else if (r < 90) begin
        send_word(ACT_UNUSED, BYTE_W'($urandom), BYTE_W'($urandom));
        continue;
      end else begin
        for (int k = 0; k < 3; k++) send_word(ACT_ENCODE, idx, BYTE_W'($urandom));
        done += 2;
      end
      done++;
    end
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_action = ACT_LOAD;
    in_byte_value = '0;
    in_code_value = '0;
    out_pop = 1'b0;
    zero_run_len = '0;
    low_half_held = 1'b0;
    held_low_nibble = '0;
    mismatches = 0;
    words_sent = 0;
    bytes_checked = 0;
    overflow_bytes = 0;
    quiet_cycles = 0;
    hold_left = 0;
    pop_gap = 0;
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_after_reset();
    test_table_extremes();
    test_long_runs();
    test_backpressure();
    test_random_traffic();

    @(negedge clk);
    in_push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input words and %0d result bytes, %0d of them with overflow",
             words_sent, bytes_checked, overflow_bytes);
    $display("mismatches: %0d, result bytes still awaited: %0d", mismatches,
             pending_bytes.size());
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
